@@ hw/rtl/gle_pkg.sv @@
// Package for the greedy line delta encoder: payload structs, op codes,
// state codes and sizing constants. No dependencies.
`timescale 1ns / 1ps
package gle_pkg;

  localparam int LINE_MAX  = 32;
  localparam int REF_DEPTH = 32;
  localparam int REF_AW    = $clog2(REF_DEPTH);
  localparam int CNT_W     = 6;
  localparam int REF_CAP   = (LINE_MAX < REF_DEPTH) ? LINE_MAX : REF_DEPTH;

  localparam logic [CNT_W-1:0] LINE_MAX_C = CNT_W'(LINE_MAX);
  localparam logic [CNT_W-1:0] REF_CAP_C  = CNT_W'(REF_CAP);
  localparam logic [CNT_W-1:0] CNT_MAX    = 6'h3F;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_COMPARE = 2'd1;
  localparam logic [1:0] ACT_FINISH  = 2'd2;

  localparam logic [1:0] OP_NONE = 2'b00;
  localparam logic [1:0] OP_EQ   = 2'b01;
  localparam logic [1:0] OP_SUB  = 2'b10;
  localparam logic [1:0] OP_ADD  = 2'b11;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SCAN = 4'd1;
  localparam logic [3:0] ST_GHDR = 4'd2;
  localparam logic [3:0] ST_GRD  = 4'd3;
  localparam logic [3:0] ST_GWR  = 4'd4;
  localparam logic [3:0] ST_EQH  = 4'd5;
  localparam logic [3:0] ST_ADDH = 4'd6;
  localparam logic [3:0] ST_ADDB = 4'd7;
  localparam logic [3:0] ST_TERM = 4'd8;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] write_address;
    logic [7:0] write_value;
    logic       overflow;
    logic       last_write;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [REF_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [REF_AW-1:0] raddr;
  } mem_req_t;

endpackage

@@ hw/rtl/gle_ref_mem.sv @@
// Reference line store: one write port, one read port, registered read data.
// Depends on gle_pkg.
`timescale 1ns / 1ps
module gle_ref_mem (
  input  logic              clk,
  input  gle_pkg::mem_req_t req,
  output logic [7:0]        rdata
);
  import gle_pkg::*;

  logic [7:0] mem_r [REF_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem_r[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/gle_out_reg.sv @@
// Output register of the result channel; parts the sequencer from out_stall.
// Depends on gle_pkg.
`timescale 1ns / 1ps
module gle_out_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          emit_valid,
  input  gle_pkg::out_t emit_data,
  output logic          emit_ok,
  output logic          out_valid,
  input  logic          out_stall,
  output gle_pkg::out_t out_data
);
  import gle_pkg::*;

  logic out_valid_r;
  out_t out_data_r;

  assign emit_ok = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_ok) begin
      out_valid_r <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ok && emit_valid) begin
      out_data_r <= emit_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/gle_ctrl.sv @@
// Sequencer: loads the reference store, scans it per compare byte and
// emits diff buffer writes. Depends on gle_pkg.
`timescale 1ns / 1ps
module gle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gle_pkg::in_t      in_data,
  output gle_pkg::mem_req_t mem_req,
  input  logic [7:0]        mem_rdata,
  output logic              emit_valid,
  output gle_pkg::out_t     emit_data,
  input  logic              emit_ok
);
  import gle_pkg::*;

  logic [3:0]       state_r, state_nxt;
  logic [CNT_W-1:0] rc_r, rc_nxt;
  logic [CNT_W-1:0] mp_r, mp_nxt;
  logic [CNT_W-1:0] cc_r, cc_nxt;
  logic [7:0]       wp_r, wp_nxt;
  logic [7:0]       hv_r, hv_nxt;
  logic [7:0]       ha_r, ha_nxt;
  logic             ovf_r, ovf_nxt;
  logic             fin_r, fin_nxt;
  logic [7:0]       b_r, b_nxt;
  logic [CNT_W-1:0] sa_r, sa_nxt;
  logic             chk_v_r, chk_v_nxt;
  logic [CNT_W-1:0] chk_a_r, chk_a_nxt;
  logic [CNT_W-1:0] ge_r, ge_nxt;

  logic             accept;
  logic             hit;
  logic [CNT_W-1:0] mp_inc;
  logic [CNT_W-1:0] gap_cnt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign hit      = chk_v_r && (mem_rdata == b_r);
  assign mp_inc   = mp_r + 1'b1;
  assign gap_cnt  = ge_r - mp_r;

  always_comb begin
    state_nxt = state_r;
    rc_nxt    = rc_r;
    mp_nxt    = mp_r;
    cc_nxt    = cc_r;
    wp_nxt    = wp_r;
    hv_nxt    = hv_r;
    ha_nxt    = ha_r;
    ovf_nxt   = ovf_r;
    fin_nxt   = fin_r;
    b_nxt     = b_r;
    sa_nxt    = sa_r;
    chk_v_nxt = 1'b0;
    chk_a_nxt = sa_r;
    ge_nxt    = ge_r;
    mem_req   = '0;
    emit_valid = 1'b0;
    emit_data  = '0;
    emit_data.overflow = ovf_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            ACT_LOAD: begin
              if (in_data.data_byte != 8'd0) begin
                if (rc_r >= REF_CAP_C) begin
                  ovf_nxt = 1'b1;
                end else begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = rc_r[REF_AW-1:0];
                  mem_req.wdata = in_data.data_byte;
                  rc_nxt        = rc_r + 1'b1;
                end
              end
            end
            ACT_COMPARE: begin
              if (in_data.data_byte != 8'd0) begin
                if (cc_r >= LINE_MAX_C) begin
                  ovf_nxt = 1'b1;
                end else begin
                  cc_nxt    = cc_r + 1'b1;
                  b_nxt     = in_data.data_byte;
                  sa_nxt    = mp_r;
                  fin_nxt   = 1'b0;
                  state_nxt = ST_SCAN;
                end
              end
            end
            ACT_FINISH: begin
              ge_nxt    = rc_r;
              fin_nxt   = 1'b1;
              state_nxt = ST_GHDR;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (hit) begin
          ge_nxt    = chk_a_r;
          state_nxt = ST_GHDR;
        end else if (sa_r >= rc_r) begin
          state_nxt = ST_ADDH;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = sa_r[REF_AW-1:0];
          chk_v_nxt     = 1'b1;
          sa_nxt        = sa_r + 1'b1;
        end
      end

      ST_GHDR: begin
        if (mp_r == ge_r) begin
          state_nxt = fin_r ? ST_TERM : ST_EQH;
        end else if (emit_ok) begin
          emit_valid              = 1'b1;
          emit_data.write_address = wp_r;
          emit_data.write_value   = {OP_SUB, gap_cnt};
          ha_nxt    = wp_r;
          hv_nxt    = {OP_SUB, gap_cnt};
          wp_nxt    = wp_r + 1'b1;
          state_nxt = ST_GRD;
        end
      end

      ST_GRD: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = mp_r[REF_AW-1:0];
        state_nxt     = ST_GWR;
      end

      ST_GWR: begin
        if (emit_ok) begin
          emit_valid              = 1'b1;
          emit_data.write_address = wp_r;
          emit_data.write_value   = mem_rdata;
          wp_nxt = wp_r + 1'b1;
          mp_nxt = mp_inc;
          if (mp_inc < ge_r) begin
            mem_req.re    = 1'b1;
            mem_req.raddr = mp_inc[REF_AW-1:0];
          end else begin
            state_nxt = fin_r ? ST_TERM : ST_EQH;
          end
        end
      end

      ST_EQH: begin
        if (emit_ok) begin
          emit_valid           = 1'b1;
          emit_data.last_write = 1'b1;
          if (hv_r[7:6] == OP_EQ && hv_r[5:0] < CNT_MAX) begin
            hv_nxt                  = hv_r + 1'b1;
            emit_data.write_address = ha_r;
            emit_data.write_value   = hv_r + 1'b1;
          end else begin
            ha_nxt                  = wp_r;
            hv_nxt                  = {OP_EQ, 6'd1};
            wp_nxt                  = wp_r + 1'b1;
            emit_data.write_address = wp_r;
            emit_data.write_value   = {OP_EQ, 6'd1};
          end
          mp_nxt    = ge_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_ADDH: begin
        if (emit_ok) begin
          emit_valid = 1'b1;
          if (hv_r[7:6] == OP_ADD && hv_r[5:0] < CNT_MAX) begin
            hv_nxt                  = hv_r + 1'b1;
            emit_data.write_address = ha_r;
            emit_data.write_value   = hv_r + 1'b1;
          end else begin
            ha_nxt                  = wp_r;
            hv_nxt                  = {OP_ADD, 6'd1};
            wp_nxt                  = wp_r + 1'b1;
            emit_data.write_address = wp_r;
            emit_data.write_value   = {OP_ADD, 6'd1};
          end
          state_nxt = ST_ADDB;
        end
      end

      ST_ADDB: begin
        if (emit_ok) begin
          emit_valid              = 1'b1;
          emit_data.last_write    = 1'b1;
          emit_data.write_address = wp_r;
          emit_data.write_value   = b_r;
          wp_nxt    = wp_r + 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      ST_TERM: begin
        if (emit_ok) begin
          emit_valid              = 1'b1;
          emit_data.last_write    = 1'b1;
          emit_data.write_address = wp_r;
          emit_data.write_value   = 8'd0;
          rc_nxt    = '0;
          mp_nxt    = '0;
          cc_nxt    = '0;
          wp_nxt    = '0;
          hv_nxt    = {OP_NONE, 6'd0};
          ha_nxt    = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rc_r    <= '0;
      mp_r    <= '0;
      cc_r    <= '0;
      wp_r    <= '0;
      hv_r    <= {OP_NONE, 6'd0};
      ha_r    <= '0;
      ovf_r   <= 1'b0;
      fin_r   <= 1'b0;
      chk_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rc_r    <= rc_nxt;
      mp_r    <= mp_nxt;
      cc_r    <= cc_nxt;
      wp_r    <= wp_nxt;
      hv_r    <= hv_nxt;
      ha_r    <= ha_nxt;
      ovf_r   <= ovf_nxt;
      fin_r   <= fin_nxt;
      chk_v_r <= chk_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b_r     <= b_nxt;
    sa_r    <= sa_nxt;
    chk_a_r <= chk_a_nxt;
    ge_r    <= ge_nxt;
  end

endmodule

@@ hw/rtl/greedy_line_delta_encoder.sv @@
// Top level of the greedy line delta encoder.
// Depends on gle_pkg, gle_ref_mem, gle_out_reg and gle_ctrl.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries an action and a byte:
//   load a reference byte, compare a byte, or finish the line.
//   Result channel (out_valid / out_stall / out_data) carries diff buffer
//   writes: address, value, overflow flag and a last_write mark on the final
//   write of each item. A run header is written again as its count grows.
//   One item is worked on at a time; in_stall is high until it is done, and
//   the next transfer can be taken the cycle after its last write.
//   Load: no writes.
//   Compare matching g bytes past the match pointer: take the byte, scan the
//   reference through the single read port, check the gap, for a nonempty
//   gap write a SUB header and copy the gap (read, then one byte per cycle
//   while the output does not stall), then write the EQ header. No match over
//   n unscanned bytes: write an ADD header and the byte. Finish: copy any tail
//   of g bytes the same way and write the terminating zero.
//   Each write is registered and reaches out_data in the cycle after it is made.
//   Reset clears the counters, the match and write pointers, the open header
//   and the overflow flag; the reference store keeps its contents and needs no clearing.
//   A stalled receiver holds the output register; the sequencer waits.
module greedy_line_delta_encoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gle_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output gle_pkg::out_t out_data
);
  import gle_pkg::*;

  mem_req_t   mem_req;
  logic [7:0] mem_rdata;
  logic       emit_valid;
  out_t       emit_data;
  logic       emit_ok;

  gle_ref_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  gle_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .emit_valid (emit_valid),
    .emit_data  (emit_data),
    .emit_ok    (emit_ok)
  );

  gle_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_data  (emit_data),
    .emit_ok    (emit_ok),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
